[design/bide_pkg.sv]
// types and constants shared by the button debounce event core
// no dependencies
package bide_pkg;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_UP    = 3'd2,
        EV_CLICK = 3'd3,
        EV_LONG  = 3'd4,
        EV_HOLD  = 3'd5
    } event_code_t;

    localparam logic [2:0] CFG_SIGMA_FLOOR       = 3'd0;
    localparam logic [2:0] CFG_SIGMA_CEILING     = 3'd1;
    localparam logic [2:0] CFG_PRESS_THRESHOLD   = 3'd2;
    localparam logic [2:0] CFG_RELEASE_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_LONG_CLICK_MS     = 3'd4;
    localparam logic [2:0] CFG_HOLD_MS           = 3'd5;
    localparam logic [2:0] CFG_ALL_EVENTS_ENABLE = 3'd6;
    localparam logic [2:0] CFG_SOURCE_ID         = 3'd7;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [7:0]  sigma_floor;
        logic [7:0]  sigma_ceiling;
        logic [7:0]  press_threshold;
        logic [7:0]  release_threshold;
        logic [15:0] long_click_ms;
        logic [15:0] hold_ms;
        logic        all_events_enable;
        logic [15:0] source_id;
    } cfg_t;

    // one tick's worth of results
    typedef struct packed {
        logic        two_events;
        event_code_t first_event;
        event_code_t second_event;
        logic        pressed;
        logic [15:0] source;
    } tick_entry_t;

endpackage

[design/bide_front.sv]
// front end: integrator, hysteresis, press timing and event classification
// depends on bide_pkg
module bide_front #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bide_pkg::cfg_t       cfg,
    input  logic                 accept,
    input  logic                 pin_level,
    input  logic [31:0]          now_ms,
    output bide_pkg::tick_entry_t entry
);

    logic [7:0]            integ_reg;
    logic [7:0]            integ_next;
    logic                  pressed_reg;
    logic                  pressed_next;
    logic                  hold_fired_reg;
    logic                  hold_fired_next;
    logic [TIME_WIDTH-1:0] start_reg;
    logic [TIME_WIDTH-1:0] start_next;

    logic [TIME_WIDTH-1:0] now_w;
    logic [TIME_WIDTH-1:0] dur;
    logic                  go_down;
    logic                  go_up;
    logic                  is_long;
    logic                  hold_hit;

    assign now_w = TIME_WIDTH'(now_ms);
    assign dur   = now_w - start_reg;

    always_comb
    begin
        integ_next = integ_reg;
        if (!pin_level)
        begin
            if (integ_reg < cfg.sigma_ceiling)
                integ_next = integ_reg + 8'd1;
        end
        else
        begin
            if (integ_reg > cfg.sigma_floor)
                integ_next = integ_reg - 8'd1;
        end
    end

    assign go_down  = !pressed_reg && (integ_next > cfg.press_threshold);
    assign go_up    = pressed_reg && (integ_next < cfg.release_threshold);
    assign is_long  = dur >= TIME_WIDTH'(cfg.long_click_ms);
    // right after a press the duration is zero
    assign hold_hit = !hold_fired_reg && (go_down ? (cfg.hold_ms == 16'd0)
                                                  : (pressed_reg && !go_up &&
                                                     dur >= TIME_WIDTH'(cfg.hold_ms)));

    assign pressed_next    = go_down || (pressed_reg && !go_up);
    assign hold_fired_next = go_up ? 1'b0 : (hold_fired_reg || hold_hit);
    assign start_next      = go_down ? now_w : start_reg;

    always_comb
    begin
        entry.pressed = pressed_next;
        entry.source  = cfg.source_id;
        priority if (go_down)
        begin
            entry.first_event  = bide_pkg::EV_DOWN;
            entry.second_event = bide_pkg::EV_HOLD;
            entry.two_events   = hold_hit;
        end
        else if (go_up)
        begin
            entry.first_event  = bide_pkg::EV_UP;
            entry.second_event = is_long ? bide_pkg::EV_LONG : bide_pkg::EV_CLICK;
            entry.two_events   = cfg.all_events_enable;
        end
        else
        begin
            entry.first_event  = hold_hit ? bide_pkg::EV_HOLD : bide_pkg::EV_NONE;
            entry.second_event = bide_pkg::EV_NONE;
            entry.two_events   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg      <= '0;
            pressed_reg    <= 1'b0;
            hold_fired_reg <= 1'b0;
            start_reg      <= '0;
        end
        else if (accept)
        begin
            integ_reg      <= integ_next;
            pressed_reg    <= pressed_next;
            hold_fired_reg <= hold_fired_next;
            start_reg      <= start_next;
        end
    end

endmodule

[design/bide_queue.sv]
// short fifo of tick entries between front and back
// depends on bide_pkg
module bide_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bide_pkg::tick_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output bide_pkg::tick_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bide_pkg::tick_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

[design/bide_back.sv]
// back end: splits each tick entry into one or two results on the output register
// depends on bide_pkg
module bide_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    input  bide_pkg::tick_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bide_pkg::event_code_t ev,
    output logic [15:0]           source,
    output logic                  pressed,
    output logic                  last
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  phase_reg;
    logic                  phase_next;
    logic                  load;
    bide_pkg::event_code_t ev_reg;
    logic [15:0]           source_reg;
    logic                  pressed_reg;
    logic                  last_reg;
    bide_pkg::event_code_t ev_next;
    logic                  last_next;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        pop        = 1'b0;
        valid_next = valid_reg;
        phase_next = phase_reg;
        ev_next    = head.first_event;
        last_next  = 1'b1;
        if (load)
        begin
            valid_next = not_empty;
            if (not_empty)
            begin
                if (phase_reg)
                begin
                    ev_next    = head.second_event;
                    pop        = 1'b1;
                    phase_next = 1'b0;
                end
                else if (head.two_events)
                begin
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && not_empty)
        begin
            ev_reg      <= ev_next;
            source_reg  <= head.source;
            pressed_reg <= head.pressed;
            last_reg    <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign ev        = ev_reg;
    assign source    = source_reg;
    assign pressed   = pressed_reg;
    assign last      = last_reg;

endmodule

[design/button_integrator_debounce_events_core.sv]
// top level of the button debounce event core: config registers, front, queue, back
// depends on bide_pkg, bide_front, bide_queue, bide_back
//
// One tick is taken per clock while the queue has room; its results leave the
// output register one per clock while out_stall is low, so a tick with a single
// result sustains one tick per cycle, and a tick with two results (down with hold,
// up with click or long click when all_events_enable is set) gives them in turn.
// The first result of a tick passes through the queue and then the output register;
// the queue of QUEUE_DEPTH tick entries lets the input run while the output stalls.
module button_integrator_debounce_events_core #(
    parameter int TIME_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        pin_level,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_code,
    output logic [15:0] event_source,
    output logic        pressed_now,
    output logic        last_of_tick
);

    bide_pkg::cfg_t        cfg_reg;
    bide_pkg::tick_entry_t front_entry;
    bide_pkg::tick_entry_t head;
    bide_pkg::event_code_t ev;
    logic                  accept;
    logic                  full;
    logic                  not_empty;
    logic                  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma_floor       <= 8'd0;
            cfg_reg.sigma_ceiling     <= 8'd12;
            cfg_reg.press_threshold   <= 8'd8;
            cfg_reg.release_threshold <= 8'd2;
            cfg_reg.long_click_ms     <= 16'd1000;
            cfg_reg.hold_ms           <= 16'd1500;
            cfg_reg.all_events_enable <= 1'b1;
            cfg_reg.source_id         <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bide_pkg::CFG_SIGMA_FLOOR:       cfg_reg.sigma_floor       <= cfg_data[7:0];
                bide_pkg::CFG_SIGMA_CEILING:     cfg_reg.sigma_ceiling     <= cfg_data[7:0];
                bide_pkg::CFG_PRESS_THRESHOLD:   cfg_reg.press_threshold   <= cfg_data[7:0];
                bide_pkg::CFG_RELEASE_THRESHOLD: cfg_reg.release_threshold <= cfg_data[7:0];
                bide_pkg::CFG_LONG_CLICK_MS:     cfg_reg.long_click_ms     <= cfg_data;
                bide_pkg::CFG_HOLD_MS:           cfg_reg.hold_ms           <= cfg_data;
                bide_pkg::CFG_ALL_EVENTS_ENABLE: cfg_reg.all_events_enable <= cfg_data[0];
                bide_pkg::CFG_SOURCE_ID:         cfg_reg.source_id         <= cfg_data;
                default:                         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;

    bide_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .pin_level (pin_level),
        .now_ms    (now_ms),
        .entry     (front_entry)
    );

    bide_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    bide_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ev        (ev),
        .source    (event_source),
        .pressed   (pressed_now),
        .last      (last_of_tick)
    );

    assign event_code = ev;

endmodule
